@@ src/rainbow_led_hsv_generator_core_assert.svh @@
// assertion macros shared by the rainbow generator rtl
`ifndef RAINBOW_LED_HSV_GENERATOR_CORE_ASSERT_SVH
`define RAINBOW_LED_HSV_GENERATOR_CORE_ASSERT_SVH

// condition that holds at every clock edge out of reset
`define RLHG_ASSERT_ALWAYS(name, clk, rst, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// same-cycle implication
`define RLHG_ASSERT_IMPLY(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define RLHG_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/rlhg_pkg.sv @@
// ----------------------------------------------------------------------------
// rlhg_pkg
// shared types and constants of the rainbow led hsv generator
// ----------------------------------------------------------------------------
`default_nettype none

package rlhg_pkg;

  // led run
  localparam int LED_TOTAL = 64;
  localparam int LED_W     = 6;
  localparam logic [LED_W-1:0] LED_LAST = LED_W'(LED_TOTAL - 1);

  // field widths
  localparam int PERIOD_W = 16;
  localparam int HUE_W    = 9;
  localparam int STEP_W   = 9;
  localparam int CH_W     = 8;
  localparam int FRAC_W   = 6;
  localparam int SECT_W   = 3;

  // hue geometry
  localparam int HUE_FULL         = 360;
  localparam int SECTOR           = 60;
  localparam int WAVE_GAP_SHIFT   = 4;   // 16 degrees per group
  localparam int WAVE_GROUP_SHIFT = 2;   // groups of four leds

  // shared multiplier and divide-by-sector reciprocal
  localparam int MUL_W       = 16;
  localparam int PROD_W      = 2 * MUL_W;
  localparam logic [MUL_W-1:0] DIV60_MUL = 16'd17477;   // ceil(2^20 / 60)
  localparam int DIV60_SHIFT = 20;

  // apb
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam logic MODE_WAVE = 1'b1;

  typedef enum logic [2:0] {
    REG_MODE,
    REG_SOLID_PERIOD,
    REG_WAVE_PERIOD,
    REG_SOLID_HUE_STEP,
    REG_WAVE_HUE_STEP,
    REG_SATURATION,
    REG_BRIGHTNESS
  } reg_idx_t;

  typedef struct packed {
    logic                mode;
    logic [PERIOD_W-1:0] solid_period;
    logic [PERIOD_W-1:0] wave_period;
    logic [STEP_W-1:0]   solid_hue_step;
    logic [STEP_W-1:0]   wave_hue_step;
    logic [CH_W-1:0]     saturation;
    logic [CH_W-1:0]     brightness;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BASE,
    ST_SPAN,
    ST_HUE,
    ST_SECT,
    ST_MUL_UP,
    ST_DIV_UP,
    ST_MUL_DN,
    ST_DIV_DN,
    ST_EMIT
  } state_t;

endpackage

`default_nettype wire

@@ src/rlhg_regs.sv @@
// ----------------------------------------------------------------------------
// rlhg_regs
// apb configuration registers of the rainbow generator
// ----------------------------------------------------------------------------
`default_nettype none

module rlhg_regs (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [rlhg_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [rlhg_pkg::DATA_W-1:0]   pwdata,
  output logic      [rlhg_pkg::DATA_W-1:0]   prdata,
  output logic                               pready,
  output rlhg_pkg::cfg_t                     cfg
);
  import rlhg_pkg::*;

  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode           <= 1'b1;
      cfg.solid_period   <= '0;
      cfg.wave_period    <= '0;
      cfg.solid_hue_step <= STEP_W'(1);
      cfg.wave_hue_step  <= STEP_W'(1);
      cfg.saturation     <= '1;
      cfg.brightness     <= '1;
    end else if (wr_en) begin
      case (idx)
        REG_MODE:           cfg.mode           <= pwdata[0];
        REG_SOLID_PERIOD:   cfg.solid_period   <= pwdata[PERIOD_W-1:0];
        REG_WAVE_PERIOD:    cfg.wave_period    <= pwdata[PERIOD_W-1:0];
        REG_SOLID_HUE_STEP: cfg.solid_hue_step <= pwdata[STEP_W-1:0];
        REG_WAVE_HUE_STEP:  cfg.wave_hue_step  <= pwdata[STEP_W-1:0];
        REG_SATURATION:     cfg.saturation     <= pwdata[CH_W-1:0];
        REG_BRIGHTNESS:     cfg.brightness     <= pwdata[CH_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (idx)
      REG_MODE:           prdata = DATA_W'(cfg.mode);
      REG_SOLID_PERIOD:   prdata = DATA_W'(cfg.solid_period);
      REG_WAVE_PERIOD:    prdata = DATA_W'(cfg.wave_period);
      REG_SOLID_HUE_STEP: prdata = DATA_W'(cfg.solid_hue_step);
      REG_WAVE_HUE_STEP:  prdata = DATA_W'(cfg.wave_hue_step);
      REG_SATURATION:     prdata = DATA_W'(cfg.saturation);
      REG_BRIGHTNESS:     prdata = DATA_W'(cfg.brightness);
      default:            prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ src/rainbow_led_hsv_generator_core.sv @@
// ----------------------------------------------------------------------------
// rainbow_led_hsv_generator_core
// tick-driven rainbow color generator with a shared-multiplier hsv converter
// ----------------------------------------------------------------------------
// Usage:
//   input channel (in_valid/in_ready, field tick): one transaction per timer
//   tick; tick 0 is taken and ignored. A tick that finds the counter at or
//   above the period of the current mode clears the counter and starts a run.
//   output channel (out_valid/out_ready): a run is 64 transactions, one per
//   led in order, with last set on the final led.
//   Colors come from one 16x16 multiplier that a sequencer reuses: a setup
//   of base and span per run, then per led the steps hue, sector, two
//   multiplies and two reciprocal divides, and emit. Each color is
//   registered at the emit step, and in_ready returns in the same cycle
//   that the last color of a run becomes valid.
//   Ticks that do not start a run are taken back to back.
//   in_ready is high only between runs; the final result of a run may still
//   wait in the output register while the next tick is taken.
//   A stalled receiver holds the sequencer at its emit step; nothing is lost.
//   Reset (rst, synchronous) clears the tick counter and hue, drops out_valid
//   and loads the register defaults. Configuration is to be written over apb
//   only while the block is between runs; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module rainbow_led_hsv_generator_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // tick channel
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          tick,
  // color channel
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [rlhg_pkg::LED_W-1:0]    led_index,
  output logic      [rlhg_pkg::CH_W-1:0]     red,
  output logic      [rlhg_pkg::CH_W-1:0]     green,
  output logic      [rlhg_pkg::CH_W-1:0]     blue,
  output logic                               last,
  // apb configuration
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [rlhg_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [rlhg_pkg::DATA_W-1:0]   pwdata,
  output logic      [rlhg_pkg::DATA_W-1:0]   prdata,
  output logic                               pready
);
  import rlhg_pkg::*;

  cfg_t cfg;

  state_t state, state_next;

  logic [PERIOD_W-1:0] tick_count;
  logic [HUE_W-1:0]    hue_now;
  logic [LED_W-1:0]    led;

  logic [PROD_W-1:0]   prod;
  logic [CH_W-1:0]     base, span, up;
  logic [HUE_W-1:0]    hue;
  logic [SECT_W-1:0]   sector;
  logic [FRAC_W-1:0]   frac;

  logic                wave, in_take, run_start, out_free, emit, last_led, mul_en;
  logic [PERIOD_W-1:0] period_sel;
  logic [STEP_W-1:0]   step_sel;
  logic [HUE_W:0]      hue_sum, adv_sum;
  logic [HUE_W-1:0]    hue_wrap, hue_adv;
  logic [SECT_W-1:0]   sector_c;
  logic [FRAC_W-1:0]   frac_c;
  logic [MUL_W-1:0]    mul_a, mul_b;
  logic [CH_W-1:0]     quot, down, v, prod_base;
  logic [CH_W-1:0]     r_c, g_c, b_c;

  rlhg_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // mode selection and handshake terms
  assign wave       = cfg.mode == MODE_WAVE;
  assign period_sel = wave ? cfg.wave_period : cfg.solid_period;
  assign step_sel   = wave ? cfg.wave_hue_step : cfg.solid_hue_step;
  assign v          = cfg.brightness;
  assign in_ready   = state == ST_IDLE;
  assign in_take    = in_valid && in_ready;
  assign run_start  = in_take && tick && (tick_count >= period_sel);
  assign out_free   = !out_valid || out_ready;
  assign emit       = (state == ST_EMIT) && out_free;
  assign last_led   = led == LED_LAST;

  // hue of the current led, wave offset of 16 per group of four
  assign hue_sum  = {1'b0, hue_now}
                  + (wave ? (HUE_W+1)'({led[LED_W-1:WAVE_GROUP_SHIFT], WAVE_GAP_SHIFT'(0)})
                          : '0);
  assign hue_wrap = (hue_sum >= (HUE_W+1)'(HUE_FULL))
                  ? HUE_W'(hue_sum - (HUE_W+1)'(HUE_FULL)) : hue_sum[HUE_W-1:0];

  // hue advance after a run, step may reach 511
  assign adv_sum = {1'b0, hue_now} + (HUE_W+1)'(step_sel);
  always_comb begin
    if (adv_sum >= (HUE_W+1)'(2 * HUE_FULL)) begin
      hue_adv = HUE_W'(adv_sum - (HUE_W+1)'(2 * HUE_FULL));
    end else if (adv_sum >= (HUE_W+1)'(HUE_FULL)) begin
      hue_adv = HUE_W'(adv_sum - (HUE_W+1)'(HUE_FULL));
    end else begin
      hue_adv = adv_sum[HUE_W-1:0];
    end
  end

  // sector and offset within the sector
  always_comb begin
    if (hue >= HUE_W'(5 * SECTOR)) begin
      sector_c = 3'd5;
      frac_c   = FRAC_W'(hue - HUE_W'(5 * SECTOR));
    end else if (hue >= HUE_W'(4 * SECTOR)) begin
      sector_c = 3'd4;
      frac_c   = FRAC_W'(hue - HUE_W'(4 * SECTOR));
    end else if (hue >= HUE_W'(3 * SECTOR)) begin
      sector_c = 3'd3;
      frac_c   = FRAC_W'(hue - HUE_W'(3 * SECTOR));
    end else if (hue >= HUE_W'(2 * SECTOR)) begin
      sector_c = 3'd2;
      frac_c   = FRAC_W'(hue - HUE_W'(2 * SECTOR));
    end else if (hue >= HUE_W'(SECTOR)) begin
      sector_c = 3'd1;
      frac_c   = FRAC_W'(hue - HUE_W'(SECTOR));
    end else begin
      sector_c = 3'd0;
      frac_c   = FRAC_W'(hue);
    end
  end

  // shared multiplier operand select
  always_comb begin
    mul_en = state inside {ST_BASE, ST_MUL_UP, ST_DIV_UP, ST_MUL_DN, ST_DIV_DN};
    case (state)
      ST_BASE: begin
        mul_a = MUL_W'(8'hFF - cfg.saturation);
        mul_b = MUL_W'(v);
      end
      ST_MUL_UP: begin
        mul_a = MUL_W'(span);
        mul_b = MUL_W'(frac);
      end
      ST_MUL_DN: begin
        mul_a = MUL_W'(span);
        mul_b = MUL_W'(FRAC_W'(SECTOR) - frac);
      end
      ST_DIV_UP, ST_DIV_DN: begin
        mul_a = prod[MUL_W-1:0];
        mul_b = DIV60_MUL;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_base = prod[2*CH_W-1:CH_W];
  assign quot      = prod[DIV60_SHIFT +: CH_W];
  assign down      = quot + base;

  // color of the current led
  always_comb begin
    if (cfg.saturation == '0) begin
      r_c = v;
      g_c = v;
      b_c = v;
    end else begin
      case (sector)
        3'd0: begin r_c = v;    g_c = up;   b_c = base; end
        3'd1: begin r_c = down; g_c = v;    b_c = base; end
        3'd2: begin r_c = base; g_c = v;    b_c = up;   end
        3'd3: begin r_c = base; g_c = down; b_c = v;    end
        3'd4: begin r_c = up;   g_c = base; b_c = v;    end
        default: begin r_c = v; g_c = base; b_c = down; end
      endcase
    end
  end

  // sequencer next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (run_start) state_next = ST_BASE;
      ST_BASE:   state_next = ST_SPAN;
      ST_SPAN:   state_next = ST_HUE;
      ST_HUE:    state_next = ST_SECT;
      ST_SECT:   state_next = ST_MUL_UP;
      ST_MUL_UP: state_next = ST_DIV_UP;
      ST_DIV_UP: state_next = ST_MUL_DN;
      ST_MUL_DN: state_next = ST_DIV_DN;
      ST_DIV_DN: state_next = ST_EMIT;
      ST_EMIT: begin
        if (out_free) state_next = last_led ? ST_IDLE : ST_HUE;
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      tick_count <= '0;
      hue_now    <= '0;
      led        <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (in_take && tick) begin
        tick_count <= (tick_count < period_sel) ? tick_count + 1'b1 : '0;
      end
      if (run_start) begin
        led <= '0;
      end else if (emit) begin
        led <= led + 1'b1;
      end
      if (emit && last_led) begin
        hue_now <= hue_adv;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath and output payload
  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod <= mul_a * mul_b;
    end
    if (state == ST_SPAN) begin
      base <= prod_base;
      span <= v - prod_base;
    end
    if (state == ST_HUE) begin
      hue <= hue_wrap;
    end
    if (state == ST_SECT) begin
      sector <= sector_c;
      frac   <= frac_c;
    end
    if (state == ST_MUL_DN) begin
      up <= quot + base;
    end
    if (emit) begin
      led_index <= led;
      red       <= r_c;
      green     <= g_c;
      blue      <= b_c;
      last      <= last_led;
    end
  end

  // checks
  `include "rainbow_led_hsv_generator_core_assert.svh"

  `RLHG_ASSERT_ALWAYS(a_hue_range, clk, rst, hue_now < HUE_W'(HUE_FULL), "hue out of range")
  `RLHG_ASSERT_IMPLY(a_last_index, clk, rst, out_valid && last, led_index == LED_LAST, "last on wrong led")
  `RLHG_ASSERT_IMPLY(a_frac_range, clk, rst, state == ST_MUL_UP, frac < FRAC_W'(SECTOR), "sector offset too big")
  `RLHG_ASSERT_NEXT(a_run_clears, clk, rst, run_start, tick_count == '0 && state == ST_BASE, "run start failed")

endmodule

`default_nettype wire

@@ verif/rlhg_color_checker.sv @@
// ----------------------------------------------------------------------------
// rlhg_color_checker
// watches the tick, color and apb channels of the rainbow generator, keeps
// its own registers, tick counter and hue, predicts the 64-led color run of
// each starting tick and compares every color transaction field by field
// ----------------------------------------------------------------------------
module rlhg_color_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic                          tick,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [rlhg_pkg::LED_W-1:0]    led_index,
  input  logic [rlhg_pkg::CH_W-1:0]     red,
  input  logic [rlhg_pkg::CH_W-1:0]     green,
  input  logic [rlhg_pkg::CH_W-1:0]     blue,
  input  logic                          last,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic                          pready,
  input  logic [rlhg_pkg::ADDR_W-1:0]   paddr,
  input  logic [rlhg_pkg::DATA_W-1:0]   pwdata,
  output int                            fail_count,
  output int                            pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import rlhg_pkg::*;

  localparam int unsigned CH_MAX = (1 << CH_W) - 1;

  typedef struct packed {
    logic [LED_W-1:0] led_index;
    logic [CH_W-1:0]  red;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  blue;
    logic             last;
  } led_color_t;

  led_color_t          color_q[$];
  cfg_t                cfg;
  logic [PERIOD_W-1:0] tick_count;
  int unsigned         hue_now;

  // six-sector integer hsv conversion, returns {red, green, blue}
  function automatic logic [3*CH_W-1:0] hsv_to_rgb(input int unsigned hue,
                                                    input int unsigned sat,
                                                    input int unsigned val);
    int unsigned base, span, frac, up, down;
    logic [CH_W-1:0] r, g, b;
    if (sat == 0) begin
      return {3{CH_W'(val)}};
    end
    base = ((CH_MAX - sat) * val) >> CH_W;
    span = val - base;
    frac = hue % SECTOR;
    up   = span * frac / SECTOR + base;
    down = span * (SECTOR - frac) / SECTOR + base;
    case (hue / SECTOR)
      0: begin
        r = CH_W'(val);  g = CH_W'(up);   b = CH_W'(base);
      end
      1: begin
        r = CH_W'(down); g = CH_W'(val);  b = CH_W'(base);
      end
      2: begin
        r = CH_W'(base); g = CH_W'(val);  b = CH_W'(up);
      end
      3: begin
        r = CH_W'(base); g = CH_W'(down); b = CH_W'(val);
      end
      4: begin
        r = CH_W'(up);   g = CH_W'(base); b = CH_W'(val);
      end
      default: begin
        r = CH_W'(val);  g = CH_W'(base); b = CH_W'(down);
      end
    endcase
    return {r, g, b};
  endfunction

  function automatic void check_field(input string name, input logic [CH_W-1:0] want,
                                      input logic [CH_W-1:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  // one tick: count toward the period, or queue a whole run and advance the hue
  function automatic void predict_tick();
    logic                wave;
    logic [PERIOD_W-1:0] period;
    logic [STEP_W-1:0]   step;
    int unsigned         hue;
    logic [3*CH_W-1:0]   rgb;
    led_color_t          c;
    wave   = (cfg.mode == MODE_WAVE);
    period = wave ? cfg.wave_period : cfg.solid_period;
    step   = wave ? cfg.wave_hue_step : cfg.solid_hue_step;
    if (tick_count < period) begin
      tick_count++;
      return;
    end
    tick_count = '0;
    for (int i = 0; i < LED_TOTAL; i++) begin
      hue = hue_now;
      if (wave) begin
        hue = (hue_now + ((i >> WAVE_GROUP_SHIFT) << WAVE_GAP_SHIFT)) % HUE_FULL;
      end
      rgb = hsv_to_rgb(hue, 32'(cfg.saturation), 32'(cfg.brightness));
      c.led_index = LED_W'(i);
      {c.red, c.green, c.blue} = rgb;
      c.last = (i == LED_TOTAL - 1);
      color_q.push_back(c);
    end
    hue_now = (hue_now + 32'(step)) % HUE_FULL;
  endfunction

  always @(posedge clk) begin : watch
    led_color_t want;
    if (rst) begin
      cfg = '{mode: MODE_WAVE, solid_period: '0, wave_period: '0,
              solid_hue_step: STEP_W'(1), wave_hue_step: STEP_W'(1),
              saturation: '1, brightness: '1};
      tick_count = '0;
      hue_now = 0;
      color_q.delete();
    end else begin
      // register write
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[ADDR_W-1:2]))
          REG_MODE:           cfg.mode = pwdata[0];
          REG_SOLID_PERIOD:   cfg.solid_period = pwdata[PERIOD_W-1:0];
          REG_WAVE_PERIOD:    cfg.wave_period = pwdata[PERIOD_W-1:0];
          REG_SOLID_HUE_STEP: cfg.solid_hue_step = pwdata[STEP_W-1:0];
          REG_WAVE_HUE_STEP:  cfg.wave_hue_step = pwdata[STEP_W-1:0];
          REG_SATURATION:     cfg.saturation = pwdata[CH_W-1:0];
          REG_BRIGHTNESS:     cfg.brightness = pwdata[CH_W-1:0];
          default: ;
        endcase
      end
      // color transaction against the oldest prediction
      if (out_valid && out_ready) begin
        if (color_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected color, expected none, got led %0d rgb %0d %0d %0d",
                   $time, led_index, red, green, blue);
        end else begin
          want = color_q.pop_front();
          check_field("led_index", CH_W'(want.led_index), CH_W'(led_index));
          check_field("red", want.red, red);
          check_field("green", want.green, green);
          check_field("blue", want.blue, blue);
          check_field("last", CH_W'(want.last), CH_W'(last));
        end
      end
      // tick transaction, a zero tick changes nothing
      if (in_valid && in_ready && tick) begin
        predict_tick();
      end
    end
    pending = color_q.size();
  end

endmodule

@@ verif/tb_rainbow_led_hsv_generator_core.sv @@
// ----------------------------------------------------------------------------
// tb_rainbow_led_hsv_generator_core
// timer ticks and apb register writes into the rainbow generator, random
// receiver ready; directed cases for reset settings, both modes, gray and
// black, oversized hue steps, hue wrap and period edges, then random phases
// with idle and stall rates and one long receiver hold-off
// ----------------------------------------------------------------------------
module tb_rainbow_led_hsv_generator_core;
  timeunit 1ns;
  timeprecision 1ps;
  import rlhg_pkg::*;

  localparam int   CYCLE_LIMIT = 3_000_000;
  localparam int   HOLD_CYCLES = 1000;
  localparam int   SETTLE_CYCLES = 16;
  localparam logic MODE_SOLID = ~MODE_WAVE;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              tick = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [LED_W-1:0]  led_index;
  logic [CH_W-1:0]   red, green, blue;
  logic              last;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  int fail_count;
  int pending;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_seq = 0;
  int cycles = 0;

  rainbow_led_hsv_generator_core DUT (.*);

  rlhg_color_checker u_checker (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_rainbow_led_hsv_generator_core NOT OK");
      $finish;
    end
  end

  // color receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin : receiver
    static int hold_seen = 0;
    static int hold_left = 0;
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // one tick transaction, returns at the falling edge after acceptance
  task automatic send_tick(input logic t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    tick <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // stop sending, wait for every predicted color, then let the block go idle
  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // register write with junk in the unused upper data bits
  task automatic apb_write(input reg_idx_t idx, input int unsigned val);
    logic [DATA_W-1:0] data;
    data = $urandom;
    case (idx)
      REG_MODE:                          data[0] = val[0];
      REG_SOLID_PERIOD, REG_WAVE_PERIOD: data[PERIOD_W-1:0] = val[PERIOD_W-1:0];
      REG_SOLID_HUE_STEP, REG_WAVE_HUE_STEP:
                                         data[STEP_W-1:0] = val[STEP_W-1:0];
      default:                           data[CH_W-1:0] = val[CH_W-1:0];
    endcase
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
  endtask

  // zero, the top value, or anything in between
  function automatic int unsigned pick_value(input int unsigned top);
    case ($urandom_range(7))
      0:       return 0;
      1:       return top;
      default: return $urandom_range(top);
    endcase
  endfunction

  task automatic random_cfg();
    apb_write(REG_MODE, $urandom_range(1));
    apb_write(REG_SOLID_PERIOD, pick_value(3));
    apb_write(REG_WAVE_PERIOD, pick_value(3));
    apb_write(REG_SOLID_HUE_STEP, pick_value(511));
    apb_write(REG_WAVE_HUE_STEP, pick_value(511));
    apb_write(REG_SATURATION, pick_value(255));
    apb_write(REG_BRIGHTNESS, pick_value(255));
  endtask

  // send n counting ticks with ignored zero ticks mixed in
  task automatic run_ticks(input int n);
    int sent;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(99) < 15) begin
        send_tick(1'b0);
      end else begin
        send_tick(1'b1);
        sent++;
      end
    end
  endtask

  initial begin : stimulus
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: wave mode, every tick starts a run
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b1);
    settle();
    // solid mode with a hue step above 359
    apb_write(REG_MODE, 32'(MODE_SOLID));
    apb_write(REG_SOLID_HUE_STEP, 511);
    send_tick(1'b1);
    send_tick(1'b1);
    settle();
    // zero saturation gives gray
    apb_write(REG_SATURATION, 0);
    apb_write(REG_BRIGHTNESS, 200);
    send_tick(1'b1);
    settle();
    // zero brightness at full saturation
    apb_write(REG_SATURATION, 255);
    apb_write(REG_BRIGHTNESS, 0);
    send_tick(1'b1);
    settle();
    // wave mode, hue wraps past 360 both across leds and between runs
    apb_write(REG_MODE, 32'(MODE_WAVE));
    apb_write(REG_SATURATION, 128);
    apb_write(REG_BRIGHTNESS, 255);
    apb_write(REG_WAVE_HUE_STEP, 359);
    send_tick(1'b1);
    send_tick(1'b1);
    settle();
    // longest period, then lowered below the count
    apb_write(REG_WAVE_PERIOD, 65535);
    repeat (4) send_tick(1'b1);
    send_tick(1'b0);
    settle();
    apb_write(REG_WAVE_PERIOD, 2);
    send_tick(1'b1);
    settle();
    // run on the tick that finds the count equal to the period
    apb_write(REG_MODE, 32'(MODE_SOLID));
    apb_write(REG_SOLID_PERIOD, 3);
    repeat (4) send_tick(1'b1);

    // random phases with different idle and stall rates
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 75; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 75; end
        default: begin send_idle_pct = 35; recv_stall_pct = 35; end
      endcase
      for (int sub = 0; sub < 3; sub++) begin
        settle();
        random_cfg();
        if (ph == 0 && sub == 0) begin
          // receiver holds off while ticks keep coming, so the block backs up
          apb_write(REG_SOLID_PERIOD, 0);
          apb_write(REG_WAVE_PERIOD, 0);
          hold_seq++;
          run_ticks(6);
        end
        run_ticks(20);
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("tb_rainbow_led_hsv_generator_core OK");
    end else begin
      $display("tb_rainbow_led_hsv_generator_core NOT OK");
    end
    $finish;
  end

endmodule
